>>> sv/signed_row_collapse_stream_defines.svh
// ----------------------------------------------------------------------------
// signed_row_collapse_stream_defines
// assertion macros shared by the signed row collapse stream rtl
// ----------------------------------------------------------------------------
`ifndef SIGNED_ROW_COLLAPSE_STREAM_DEFINES_SVH
`define SIGNED_ROW_COLLAPSE_STREAM_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SRCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/srcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcs_pkg
// types, constants and sequencer states of the signed row collapse stream
// ----------------------------------------------------------------------------
package srcs_pkg;

	localparam int KEY_W               = 64;
	localparam int REF_W               = 32;
	localparam int QUEUE_DEPTH_DEFAULT = 64;

	typedef struct packed {
		logic             end_of_stream;
		logic [KEY_W-1:0] row_key;
		logic             row_negative;
		logic [REF_W-1:0] row_ref;
	} srcs_in_word_t;

	typedef struct packed {
		logic [REF_W-1:0] out_ref;
		logic [KEY_W-1:0] out_key;
		logic             out_negative;
		logic             run_end;
	} srcs_out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_EMIT
	} srcs_state_t;

	typedef struct packed {
		logic idle;
		logic emit;
		logic empty;
	} srcs_status_t;

endpackage

>>> sv/srcs_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcs_ring
// reference ring storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srcs_ring #(
	parameter int QUEUE_DEPTH = srcs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
	input  logic [srcs_pkg::REF_W-1:0]       wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
	output logic [srcs_pkg::REF_W-1:0]       rd_data
);

	logic [srcs_pkg::REF_W-1:0] mem_q [QUEUE_DEPTH];
	logic [srcs_pkg::REF_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/srcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcs_ctrl
// sequencer: key compare, push / cancel decision and queue drain
// ----------------------------------------------------------------------------
module srcs_ctrl #(
	parameter int QUEUE_DEPTH = srcs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_take,
	input  srcs_pkg::srcs_in_word_t          item,
	input  logic                             emit_ok,
	output srcs_pkg::srcs_out_word_t         emit_word,
	output srcs_pkg::srcs_status_t           status,
	output logic                             ring_wr_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0]   ring_wr_addr,
	output logic [srcs_pkg::REF_W-1:0]       ring_wr_data,
	output logic                             ring_rd_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0]   ring_rd_addr,
	input  logic [srcs_pkg::REF_W-1:0]       ring_rd_data
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	srcs_pkg::srcs_state_t   state_q, state_d;
	srcs_pkg::srcs_in_word_t item_q;
	logic [srcs_pkg::KEY_W-1:0] key_q;
	logic                       neg_q;
	logic [IDX_W-1:0]           head_q;
	logic [CNT_W-1:0]           count_q;
	logic                       drain_all_q;

	logic             empty, full, key_diff;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail_idx, head_inc;

	// control strobes
	logic do_clear, do_push, do_cancel, do_set_key, do_emit, do_latch;
	logic set_drain, drain_val;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign key_diff = (item_q.row_key != key_q);

	// tail = (head + count) mod depth, sum stays below twice the depth
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
	assign head_inc = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srcs_pkg::ST_IDLE: begin
				if (item_take) begin
					state_d = srcs_pkg::ST_DECIDE;
				end
			end
			srcs_pkg::ST_DECIDE: begin
				if (item_q.end_of_stream) begin
					state_d = empty ? srcs_pkg::ST_IDLE : srcs_pkg::ST_READ;
				end else if (!empty && (key_diff || full)) begin
					state_d = srcs_pkg::ST_READ;
				end else begin
					state_d = srcs_pkg::ST_IDLE;
				end
			end
			srcs_pkg::ST_READ: begin
				state_d = srcs_pkg::ST_EMIT;
			end
			srcs_pkg::ST_EMIT: begin
				if (emit_ok) begin
					state_d = (drain_all_q && count_q != CNT_W'(1)) ?
						srcs_pkg::ST_READ : srcs_pkg::ST_DECIDE;
				end
			end
			default: state_d = srcs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		do_clear   = 1'b0;
		do_push    = 1'b0;
		do_cancel  = 1'b0;
		do_set_key = 1'b0;
		do_emit    = 1'b0;
		do_latch   = 1'b0;
		set_drain  = 1'b0;
		drain_val  = 1'b0;
		ring_rd_en = 1'b0;
		unique case (state_q)
			srcs_pkg::ST_IDLE: begin
				do_latch = item_take;
			end
			srcs_pkg::ST_DECIDE: begin
				if (item_q.end_of_stream) begin
					if (empty) begin
						do_clear = 1'b1;
					end else begin
						set_drain = 1'b1;
						drain_val = 1'b1;
					end
				end else if (!empty && key_diff) begin
					set_drain = 1'b1;
					drain_val = 1'b1;
				end else if (!empty && full) begin
					set_drain = 1'b1;
				end else if (empty) begin
					do_set_key = 1'b1;
					do_push    = 1'b1;
				end else if (item_q.row_negative == neg_q) begin
					do_push = 1'b1;
				end else begin
					do_cancel = 1'b1;
				end
			end
			srcs_pkg::ST_READ: begin
				ring_rd_en = 1'b1;
			end
			srcs_pkg::ST_EMIT: begin
				do_emit = emit_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srcs_pkg::ST_IDLE;
			key_q       <= '0;
			neg_q       <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			drain_all_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_drain) begin
				drain_all_q <= drain_val;
			end
			if (do_set_key) begin
				key_q <= item_q.row_key;
				neg_q <= item_q.row_negative;
			end
			if (do_clear) begin
				key_q   <= '0;
				neg_q   <= 1'b0;
				head_q  <= '0;
				count_q <= '0;
			end else if (do_push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_cancel) begin
				count_q <= count_q - CNT_W'(1);
			end else if (do_emit) begin
				head_q  <= head_inc;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_latch) begin
			item_q <= item;
		end
	end

	assign ring_wr_en   = do_push;
	assign ring_wr_addr = tail_idx;
	assign ring_wr_data = item_q.row_ref;
	assign ring_rd_addr = head_q;

	assign emit_word.out_ref      = ring_rd_data;
	assign emit_word.out_key      = key_q;
	assign emit_word.out_negative = neg_q;
	// a single overflow word, or the last word of a full drain
	assign emit_word.run_end      = !drain_all_q || (count_q == CNT_W'(1));

	assign status.idle  = (state_q == srcs_pkg::ST_IDLE);
	assign status.emit  = (state_q == srcs_pkg::ST_EMIT);
	assign status.empty = empty;

endmodule

>>> sv/signed_row_collapse_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_row_collapse_stream
// collapses key-sorted signed rows through a ring queue of references
//
// channel   handshake                     word
// item      item_valid / item_stall       srcs_in_word_t
// result    result_valid / result_stall   srcs_out_word_t
//
// a row that emits nothing passes only through accept, then decide
// each emitted word adds a ring read, then an output register load
// one item is handled at a time; item_stall is high until its words are queued
// result_stall holds the output register and freezes the drain in place
// no clearing pass after reset: the ring is only read where it was written
// ----------------------------------------------------------------------------
`include "signed_row_collapse_stream_defines.svh"

module signed_row_collapse_stream #(
	parameter int QUEUE_DEPTH = srcs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  srcs_pkg::srcs_in_word_t  item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output srcs_pkg::srcs_out_word_t result
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	srcs_pkg::srcs_status_t   status;
	srcs_pkg::srcs_out_word_t emit_word;
	srcs_pkg::srcs_out_word_t result_q;
	logic                     result_valid_q;
	logic                     item_take, emit_ok, load;

	logic                       ring_wr_en, ring_rd_en;
	logic [IDX_W-1:0]           ring_wr_addr, ring_rd_addr;
	logic [srcs_pkg::REF_W-1:0] ring_wr_data, ring_rd_data;

	assign item_stall = !status.idle;
	assign item_take  = item_valid && !item_stall;
	assign emit_ok    = !result_valid_q || !result_stall;
	assign load       = status.emit && emit_ok;

	srcs_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_take   (item_take),
		.item        (item),
		.emit_ok     (emit_ok),
		.emit_word   (emit_word),
		.status      (status),
		.ring_wr_en  (ring_wr_en),
		.ring_wr_addr(ring_wr_addr),
		.ring_wr_data(ring_wr_data),
		.ring_rd_en  (ring_rd_en),
		.ring_rd_addr(ring_rd_addr),
		.ring_rd_data(ring_rd_data)
	);

	srcs_ring #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_wr_en),
		.wr_addr(ring_wr_addr),
		.wr_data(ring_wr_data),
		.rd_en  (ring_rd_en),
		.rd_addr(ring_rd_addr),
		.rd_data(ring_rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= emit_word;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`SRCS_ASSERT_NOW(a_load_free, clk, arst_n, load, emit_ok, "load over a held word")
	`SRCS_ASSERT_NOW(a_emit_nonempty, clk, arst_n, status.emit, !status.empty, "empty at emit")
	`SRCS_ASSERT_NEXT(a_take_busy, clk, arst_n, item_take, !status.idle, "idle after take")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for signed_row_collapse_stream: a behavioral collapse
// of the row queue predicts every output word, random idle and stall on both
// channels, plus a long output hold that backs the block up into its input
// ----------------------------------------------------------------------------
module tb;

	localparam int KEY_W        = srcs_pkg::KEY_W;
	localparam int REF_W        = srcs_pkg::REF_W;
	localparam int DEPTH        = srcs_pkg::QUEUE_DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int TAIL_CYCLES  = 20;
	localparam int RANDOM_ITEMS = 90;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	srcs_pkg::srcs_in_word_t  item         = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	srcs_pkg::srcs_out_word_t result;

	// behavioral copy of the collapse queue
	logic [REF_W-1:0]         open_refs[$];
	logic [KEY_W-1:0]         open_key;
	logic                     open_negative;
	srcs_pkg::srcs_out_word_t expected_words[$];
	srcs_pkg::srcs_out_word_t next_word;

	int  error_count = 0;
	int  cycle_count = 0;
	int  stall_left  = 0;
	int  hold_left   = 0;
	bit  idle_off    = 1'b0;

	signed_row_collapse_stream #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic srcs_pkg::srcs_in_word_t row_word(logic eos, logic [KEY_W-1:0] key,
			logic neg, logic [REF_W-1:0] ref_id);
		srcs_pkg::srcs_in_word_t w;
		w.end_of_stream = eos;
		w.row_key       = key;
		w.row_negative  = neg;
		w.row_ref       = ref_id;
		return w;
	endfunction

	function automatic logic [KEY_W-1:0] any_key();
		return {$urandom, $urandom};
	endfunction

	function automatic void drain_oldest();
		srcs_pkg::srcs_out_word_t w;
		w.out_ref      = open_refs.pop_front();
		w.out_key      = open_key;
		w.out_negative = open_negative;
		w.run_end      = 1'b0;
		expected_words.push_back(w);
	endfunction

	// one accepted word in, its emitted words out to expected_words
	function automatic void collapse_row(srcs_pkg::srcs_in_word_t w);
		int                       emitted;
		srcs_pkg::srcs_out_word_t last_w;
		emitted = expected_words.size();
		if (w.end_of_stream) begin
			while (open_refs.size() > 0)
				drain_oldest();
			open_key      = '0;
			open_negative = 1'b0;
		end else begin
			if (open_refs.size() > 0) begin
				if (w.row_key != open_key) begin
					while (open_refs.size() > 0)
						drain_oldest();
				end else if (open_refs.size() >= DEPTH) begin
					drain_oldest();
				end
			end
			if (open_refs.size() == 0) begin
				open_key      = w.row_key;
				open_negative = w.row_negative;
				open_refs.push_back(w.row_ref);
			end else if (w.row_negative == open_negative) begin
				open_refs.push_back(w.row_ref);
			end else begin
				void'(open_refs.pop_back());
			end
		end
		if (expected_words.size() > emitted) begin
			last_w = expected_words.pop_back();
			last_w.run_end = 1'b1;
			expected_words.push_back(last_w);
		end
	endfunction

	task automatic send_item(srcs_pkg::srcs_in_word_t w);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= w;
		do
			@(posedge clk);
		while (item_stall);
		collapse_row(w);
	endtask

	function automatic void compare_field(string name, logic [KEY_W-1:0] expv,
			logic [KEY_W-1:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s expected %h actual %h", $time, name, expv, actv);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: word with none expected, expected nothing actual ref %h key %h",
					$time, result.out_ref, result.out_key);
				error_count++;
			end else begin
				next_word = expected_words.pop_front();
				compare_field("out_ref", KEY_W'(next_word.out_ref), KEY_W'(result.out_ref));
				compare_field("out_key", next_word.out_key, result.out_key);
				compare_field("out_negative", KEY_W'(next_word.out_negative),
					KEY_W'(result.out_negative));
				compare_field("run_end", KEY_W'(next_word.run_end), KEY_W'(result.run_end));
			end
			stall_left = idle_off ? 0 : $urandom_range(0, 4);
		end
	end

	// long holds first, then the per-word stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic test_directed();
		logic [KEY_W-1:0] top_key;
		top_key = '1;
		send_item(row_word(1'b1, '0, 1'b0, '0));                    // flush of empty queue
		send_item(row_word(1'b0, '0, 1'b0, '0));
		send_item(row_word(1'b0, '0, 1'b1, '1));                    // cancel to empty
		send_item(row_word(1'b0, top_key, 1'b1, '1));               // new key on empty queue
		send_item(row_word(1'b0, top_key, 1'b1, 32'h1234_5678));
		send_item(row_word(1'b0, top_key, 1'b0, 32'h0000_0001));    // cancels newest
		send_item(row_word(1'b0, top_key, 1'b1, 32'ha5a5_a5a5));
		send_item(row_word(1'b0, '0, 1'b0, 32'h8000_0000));         // key change drains two
		send_item(row_word(1'b0, 64'h8000_0000_0000_0000, 1'b0, 32'h5a5a_5a5a));
		send_item(row_word(1'b1, top_key, 1'b1, '1));               // flush ignores payload
		send_item(row_word(1'b0, 64'd5, 1'b0, 32'd10));
		send_item(row_word(1'b0, 64'd5, 1'b1, 32'd11));
		send_item(row_word(1'b0, 64'd3, 1'b1, 32'd12));             // any key after cancel
		send_item(row_word(1'b0, 64'd3, 1'b1, 32'd13));
		send_item(row_word(1'b0, 64'd3, 1'b1, 32'd14));
		send_item(row_word(1'b0, 64'd3, 1'b0, 32'd15));
		send_item(row_word(1'b1, '0, 1'b0, '0));
		send_item(row_word(1'b1, '0, 1'b1, 32'hffff_0000));
	endtask

	// fill to depth, overflow by a few, then cancel against a full queue
	task automatic test_full_queue();
		logic [KEY_W-1:0] key;
		logic             neg;
		key      = any_key();
		neg      = 1'($urandom_range(0, 1));
		idle_off = 1'b1;
		repeat (DEPTH + 3)
			send_item(row_word(1'b0, key, neg, $urandom));
		idle_off = 1'b0;
		send_item(row_word(1'b0, key, ~neg, $urandom));
		send_item(row_word(1'b0, key, neg, $urandom));
		send_item(row_word(1'b1, any_key(), 1'($urandom_range(0, 1)), $urandom));
	endtask

	// key groups, ascending or at a random new key, with mixed signs, some flushes and some noise words
	task automatic test_random_groups();
		logic [KEY_W-1:0] key;
		logic             neg;
		int               sent;
		int               pick;
		int               rows;
		key  = '0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_item(row_word(1'($urandom_range(0, 1)), any_key(),
					1'($urandom_range(0, 1)), $urandom));
				sent++;
			end else if (pick < 3) begin
				send_item(row_word(1'b1, any_key(), 1'($urandom_range(0, 1)), $urandom));
				sent++;
			end else begin
				if (pick < 5)
					key = any_key();
				else
					key = key + 64'($urandom_range(1, 3));
				idle_off = (pick == 19);
				rows     = $urandom_range(1, 6);
				neg      = 1'($urandom_range(0, 1));
				repeat (rows) begin
					if ($urandom_range(0, 2) == 0)
						neg = ~neg;
					send_item(row_word(1'b0, key, neg, $urandom));
					sent++;
				end
				idle_off = 1'b0;
			end
		end
	endtask

	// receiver holds while every row changes key, so the block backs up into its input
	task automatic test_output_backpressure();
		logic [KEY_W-1:0] key;
		key       = any_key();
		hold_left = 300;
		repeat (30) begin
			key = key + 64'd1;
			send_item(row_word(1'b0, key, 1'($urandom_range(0, 1)), $urandom));
		end
		send_item(row_word(1'b1, '0, 1'b0, $urandom));
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		open_key      = '0;
		open_negative = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_queue();
		test_random_groups();
		test_output_backpressure();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/srcs_pkg.sv
sv/srcs_ring.sv
sv/srcs_ctrl.sv
sv/signed_row_collapse_stream.sv
dv/tb.sv
